FILE: hw/rtl/utbc_pkg.sv
// Shared types, constants and helpers for the text buffer with cursor.
// Depends on nothing; the front end, back end, newline detector and top level import it.
package utbc_pkg;

   localparam int STORE_BYTES_DEF = 256;
   localparam int POS_OUT_W       = 9;
   localparam int UNITS_W         = 5;
   localparam int OFF_W           = 11;
   localparam logic [UNITS_W-1:0] MAX_UNITS = 5'd16;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_PUT   = 2'd1,
      CMD_SEEK  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_DATA  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   localparam logic [1:0] WH_START  = 2'd0;
   localparam logic [1:0] WH_CURSOR = 2'd1;
   localparam logic [1:0] WH_END    = 2'd2;
   localparam logic [1:0] WH_NONE   = 2'd3;

   typedef struct packed {
      cmd_type                  command;
      logic [7:0]               data_byte;
      logic signed [OFF_W-1:0]  seek_offset;
      logic [1:0]               whence;
      logic                     unit_is_char;
      logic [UNITS_W-1:0]       units;
   } job_type;

   // Length in bytes of the UTF-8 sequence that starts with the given byte.
   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] n;
      if (b < 8'h80) n = 3'd1;
      else if ((b & 8'hE0) == 8'hC0) n = 3'd2;
      else if ((b & 8'hF0) == 8'hE0) n = 3'd3;
      else if ((b & 8'hF8) == 8'hF0) n = 3'd4;
      else n = 3'd1;
      return n;
   endfunction

endpackage

FILE: hw/rtl/utbc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module utbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end
endmodule

FILE: hw/rtl/utbc_front.sv
// Front end: accepts request transactions, clamps the unit count and
// holds them in a two-entry queue for the back end. Uses utbc_pkg.
module utbc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_command,
   input  logic [7:0]                    req_data_byte,
   input  logic signed [utbc_pkg::OFF_W-1:0] req_seek_offset,
   input  logic [1:0]                    req_whence,
   input  logic                          req_unit_is_char,
   input  logic [utbc_pkg::UNITS_W-1:0]  req_unit_count,
   output logic                          job_valid,
   output utbc_pkg::job_type             job,
   input  logic                          job_pop
);
   import utbc_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push_ok, pop_ok;
   job_type    incoming;

   assign req_full  = (count_ff == 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign job       = slot_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = job_pop && job_valid;

   always_comb begin
      incoming.command      = cmd_type'(req_command);
      incoming.data_byte    = req_data_byte;
      incoming.seek_offset  = req_seek_offset;
      incoming.whence       = req_whence;
      incoming.unit_is_char = req_unit_is_char;
      incoming.units        = (req_unit_count > MAX_UNITS) ? MAX_UNITS : req_unit_count;
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push_ok) wr_ptr_ff <= !wr_ptr_ff;
         if (pop_ok) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push_ok) - 2'(pop_ok);
      end
   end
endmodule

FILE: hw/rtl/utbc_back.sv
// Back end: executes queued jobs against the text RAM and drives the
// result register. Uses utbc_pkg, utbc_ram and utbc_text_buffer.
module utbc_back #(
   parameter int STORE_BYTES = utbc_pkg::STORE_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            job_valid,
   input  utbc_pkg::job_type               job,
   output logic                            job_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [1:0]                      rsp_status,
   output logic [7:0]                      rsp_byte_out,
   output logic [utbc_pkg::POS_OUT_W-1:0]  rsp_cursor,
   output logic [utbc_pkg::POS_OUT_W-1:0]  rsp_fill_length,
   output logic                            rsp_last
);
   import utbc_pkg::*;

   localparam int AW = $clog2(STORE_BYTES);
   localparam int PW = $clog2(STORE_BYTES + 5);
   localparam int TW = ((PW > OFF_W) ? PW : OFF_W) + 2;
   localparam logic [PW-1:0] STORE_POS  = PW'(STORE_BYTES);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(STORE_BYTES - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_DONE, S_EMPTY, S_COUNT, S_COUNT_W,
      S_WALK, S_WALK_W, S_RD_ISSUE, S_RD_DATA
   } state_type;

   state_type state_ff, state_in;
   logic [PW-1:0] cur_ff, cur_in, len_ff, len_in, p_ff, p_in, n_ff, n_in;
   logic [PW-1:0] limit_ff, limit_in;
   logic signed [TW-1:0] target_ff, target_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [2:0] rem_ff, rem_in;
   logic [UNITS_W-1:0] done_ff, done_in, units_ff, units_in;
   logic [7:0] first_ff, first_in;
   logic by_char_ff, by_char_in, notify_ff, notify_in;

   logic out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [1:0] out_status_ff, out_status_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [POS_OUT_W-1:0] out_cur_ff, out_cur_in, out_len_ff, out_len_in;

   logic we;
   logic [AW-1:0] waddr, raddr;
   logic [7:0] wdata, rdata;
   logic out_free;
   logic signed [TW-1:0] np, off_ext;
   logic [PW-1:0] base, diff, cur_inc, step;
   logic [2:0] sl, eff_rem;
   logic [7:0] first_now;
   logic first_is_nl;
   logic is_last;

   utbc_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata_ff(rdata)
   );

   utbc_text_buffer u_newline (
      .byte_in(first_now), .is_newline(first_is_nl)
   );

   assign out_free        = !out_valid_ff || rsp_pop;
   assign rsp_empty       = !out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_byte_out    = out_byte_ff;
   assign rsp_cursor      = out_cur_ff;
   assign rsp_fill_length = out_len_ff;
   assign rsp_last        = out_last_ff;

   assign off_ext = TW'(job.seek_offset);
   assign sl      = seq_len(rdata);
   assign step    = PW'(sl);
   assign cur_inc = cur_ff + PW'(1);
   assign diff    = len_ff - cur_ff;

   always_comb begin
      unique case (job.whence)
         WH_START:  base = '0;
         WH_CURSOR: base = cur_ff;
         default:   base = len_ff;
      endcase
      np = $signed(TW'(base)) + off_ext;
      if (rem_ff == 3'd0) begin
         first_now = rdata;
         // In byte units every byte is a unit of its own.
         if (!by_char_ff) eff_rem = 3'd1;
         else eff_rem = (PW'(sl) > diff) ? 3'(diff) : sl;
      end else begin
         first_now = first_ff;
         eff_rem   = rem_ff;
      end
      is_last = (eff_rem == 3'd1) && ((done_ff + UNITS_W'(1) == units_ff)
                || first_is_nl || (cur_inc >= len_ff));
   end

   always_comb begin
      state_in = state_ff;   cur_in = cur_ff;     len_in = len_ff;
      p_in = p_ff;           n_in = n_ff;         limit_in = limit_ff;
      target_in = target_ff; sweep_in = sweep_ff; rem_in = rem_ff;
      done_in = done_ff;     units_in = units_ff; first_in = first_ff;
      by_char_in = by_char_ff; notify_in = notify_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_status_in = out_status_ff; out_byte_in = out_byte_ff;
      out_cur_in = out_cur_ff; out_len_in = out_len_ff; out_last_in = out_last_ff;
      job_pop = 1'b0;
      we = 1'b0; waddr = cur_ff[AW-1:0]; wdata = job.data_byte;
      raddr = p_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               unique case (job.command)
                  CMD_CLEAR: begin
                     sweep_in  = '0;
                     notify_in = 1'b1;
                     state_in  = S_CLEAR;
                  end
                  CMD_PUT: begin
                     if (cur_ff < STORE_POS) begin
                        we     = 1'b1;
                        cur_in = cur_inc;
                        if (cur_inc > len_ff) len_in = cur_inc;
                     end
                     state_in = S_DONE;
                  end
                  CMD_SEEK: begin
                     p_in = '0;
                     n_in = '0;
                     state_in = S_DONE;
                     if (job.whence != WH_NONE) begin
                        if (!job.unit_is_char) begin
                           if (np < 0) cur_in = '0;
                           else if (np > $signed(TW'(STORE_POS))) cur_in = STORE_POS;
                           else cur_in = PW'(np);
                        end else if (job.whence == WH_START) begin
                           target_in = off_ext;
                           state_in  = S_WALK;
                        end else begin
                           target_in = off_ext;
                           limit_in  = (job.whence == WH_CURSOR) ? cur_ff : len_ff;
                           state_in  = S_COUNT;
                        end
                     end
                  end
                  default: begin
                     if (cur_ff >= len_ff || job.units == '0) begin
                        state_in = S_EMPTY;
                     end else begin
                        units_in   = job.units;
                        by_char_in = job.unit_is_char;
                        done_in    = '0;
                        rem_in     = 3'd0;
                        state_in   = S_RD_ISSUE;
                     end
                  end
               endcase
            end
         end
         S_CLEAR: begin
            we       = 1'b1;
            waddr    = sweep_ff;
            wdata    = (sweep_ff == LAST_ADDR) ? 8'h00 : CHAR_SPACE;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == LAST_ADDR) begin
               cur_in   = '0;
               len_in   = '0;
               state_in = notify_ff ? S_DONE : S_IDLE;
            end
         end
         S_DONE, S_EMPTY: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = (state_ff == S_DONE) ? ST_DONE : ST_EMPTY;
               out_byte_in   = 8'h00;
               out_cur_in    = POS_OUT_W'(cur_ff);
               out_len_in    = POS_OUT_W'(len_ff);
               out_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_COUNT: begin
            if (p_ff < limit_ff) begin
               state_in = S_COUNT_W;
            end else begin
               target_in = $signed(TW'(n_ff)) + target_ff;
               p_in = '0;
               n_in = '0;
               state_in = S_WALK;
            end
         end
         S_COUNT_W: begin
            p_in = p_ff + step;
            n_in = n_ff + PW'(1);
            state_in = S_COUNT;
         end
         S_WALK: begin
            if (p_ff < STORE_POS && $signed(TW'(n_ff)) < target_ff) begin
               state_in = S_WALK_W;
            end else begin
               cur_in   = (p_ff > STORE_POS) ? STORE_POS : p_ff;
               state_in = S_DONE;
            end
         end
         S_WALK_W: begin
            p_in = p_ff + step;
            n_in = n_ff + PW'(1);
            state_in = S_WALK;
         end
         S_RD_ISSUE: begin
            raddr    = cur_ff[AW-1:0];
            state_in = S_RD_DATA;
         end
         default: begin
            raddr = cur_ff[AW-1:0];
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = ST_DATA;
               out_byte_in   = rdata;
               out_cur_in    = POS_OUT_W'(cur_inc);
               out_len_in    = POS_OUT_W'(len_ff);
               out_last_in   = is_last;
               cur_in        = cur_inc;
               first_in      = first_now;
               rem_in        = (by_char_ff ? eff_rem : 3'd1) - 3'd1;
               if (!by_char_ff || eff_rem == 3'd1) done_in = done_ff + UNITS_W'(1);
               state_in      = is_last ? S_IDLE : S_RD_ISSUE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;       n_ff <= n_in;
      limit_ff <= limit_in; target_ff <= target_in; rem_ff <= rem_in;
      done_ff <= done_in; units_ff <= units_in; first_ff <= first_in;
      by_char_ff <= by_char_in;
      out_status_ff <= out_status_in; out_byte_ff <= out_byte_in;
      out_cur_ff <= out_cur_in; out_len_ff <= out_len_in; out_last_ff <= out_last_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         notify_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         cur_ff       <= '0;
         len_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         notify_ff    <= notify_in;
         out_valid_ff <= out_valid_in;
         cur_ff       <= cur_in;
         len_ff       <= len_in;
      end
   end
endmodule

FILE: hw/rtl/utbc_text_buffer.sv
// Newline detector for the lead byte of the character being read.
// Depends on utbc_pkg only; used by the back end.
module utbc_text_buffer (
   input  logic [7:0] byte_in,
   output logic       is_newline
);
   import utbc_pkg::*;
   assign is_newline = (byte_in == CHAR_NEWLINE);
endmodule

FILE: hw/rtl/utf8_text_buffer_cursor.sv
// Top level of the text buffer with cursor: front queue, back executor.
// Depends on utbc_pkg, utbc_front, utbc_back, utbc_text_buffer and utbc_ram.
//
//   channel   handshake          payload
//   request   req_push/req_full  command, data byte, seek offset, whence, unit, count
//   response  rsp_pop/rsp_empty  status, byte out, cursor, fill length, last
//
// Put, byte seek, ignored seek and empty reads pass from the idle state to the
// done or empty state, which writes the response once the register is free.
// A clear sweeps the text RAM at one entry a cycle.
// Character seeks walk the text one character at a time through the RAM's
// registered read port; reads issue an address, then deliver its byte once the response register is free.
// After reset the same sweep runs over every entry before jobs start;
// requests are queued meanwhile until the two-entry front queue is full.
// A stalled response holds the back end while the front keeps accepting.
module utf8_text_buffer_cursor #(
   parameter int STORE_BYTES = utbc_pkg::STORE_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [1:0]                         req_command,
   input  logic [7:0]                         req_data_byte,
   input  logic signed [utbc_pkg::OFF_W-1:0]  req_seek_offset,
   input  logic [1:0]                         req_whence,
   input  logic                               req_unit_is_char,
   input  logic [utbc_pkg::UNITS_W-1:0]       req_unit_count,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [1:0]                         rsp_status,
   output logic [7:0]                         rsp_byte_out,
   output logic [utbc_pkg::POS_OUT_W-1:0]     rsp_cursor,
   output logic [utbc_pkg::POS_OUT_W-1:0]     rsp_fill_length,
   output logic                               rsp_last
);
   import utbc_pkg::*;

   job_type job;
   logic    job_valid, job_pop;

   // The front end only queues and normalizes transactions.
   utbc_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_command(req_command), .req_data_byte(req_data_byte),
      .req_seek_offset(req_seek_offset), .req_whence(req_whence),
      .req_unit_is_char(req_unit_is_char), .req_unit_count(req_unit_count),
      .job_valid(job_valid), .job(job), .job_pop(job_pop)
   );

   // The back end owns the text RAM, cursor, length and response register.
   utbc_back #(.STORE_BYTES(STORE_BYTES)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job(job), .job_pop(job_pop),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_status(rsp_status), .rsp_byte_out(rsp_byte_out),
      .rsp_cursor(rsp_cursor), .rsp_fill_length(rsp_fill_length),
      .rsp_last(rsp_last)
   );
endmodule
